[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/pcv_pkg.sv]
// Program container validator package: phase enum, status codes, CSR indexes,
// config and step structs, and the per-byte UTF-8 step function. No dependencies.
package pcv_pkg;

   typedef logic [3:0] status_type;

   localparam status_type ST_OK       = 4'd0;
   localparam status_type ST_TRUNC    = 4'd1;
   localparam status_type ST_MAGIC    = 4'd2;
   localparam status_type ST_VERSION  = 4'd3;
   localparam status_type ST_FLAGS    = 4'd4;
   localparam status_type ST_COUNT    = 4'd5;
   localparam status_type ST_OPCODE   = 4'd6;
   localparam status_type ST_TAG      = 4'd7;
   localparam status_type ST_OPUTF8   = 4'd8;
   localparam status_type ST_TRAILING = 4'd9;
   localparam status_type ST_IMGUTF8  = 4'd10;
   localparam status_type ST_NOSTOP   = 4'd11;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type CSR_MAGIC        = 3'd0;
   localparam csr_index_type CSR_VERSION      = 3'd1;
   localparam csr_index_type CSR_MAX_INSTR    = 3'd2;
   localparam csr_index_type CSR_MAX_OPERAND  = 3'd3;
   localparam csr_index_type CSR_MAX_IMAGE    = 3'd4;

   localparam logic [31:0] RST_MAGIC       = 32'd0;
   localparam logic [15:0] RST_VERSION     = 16'd1;
   localparam logic [31:0] RST_MAX_INSTR   = 32'd65536;
   localparam logic [31:0] RST_MAX_OPERAND = 32'd4096;
   localparam logic [31:0] RST_MAX_IMAGE   = 32'd1048576;

   localparam logic [7:0] OPCODE_MIN = 8'h01;
   localparam logic [7:0] OPCODE_STOP = 8'h10;
   localparam logic [7:0] TAG_NONE    = 8'h00;
   localparam logic [7:0] TAG_OPERAND = 8'h01;

   localparam logic [7:0] UTF8_CONT_MASK = 8'hc0;
   localparam logic [7:0] UTF8_CONT_CODE = 8'h80;
   localparam logic [7:0] UTF8_LEAD2_MASK = 8'he0;
   localparam logic [7:0] UTF8_LEAD2_CODE = 8'hc0;
   localparam logic [7:0] UTF8_LEAD2_MIN  = 8'hc2;
   localparam logic [7:0] UTF8_LEAD3_MASK = 8'hf0;
   localparam logic [7:0] UTF8_LEAD3_CODE = 8'he0;
   localparam logic [7:0] UTF8_LEAD4_MASK = 8'hf8;
   localparam logic [7:0] UTF8_LEAD4_CODE = 8'hf0;
   localparam logic [7:0] UTF8_LEAD4_MAX  = 8'hf4;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_OPCODE  = 4'd1,
      PH_TAG     = 4'd2,
      PH_OPLEN   = 4'd3,
      PH_OPDATA  = 4'd4,
      PH_IMGLEN  = 4'd5,
      PH_IMGDATA = 4'd6,
      PH_DONE    = 4'd7,
      PH_DRAIN   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [31:0] magic_word;
      logic [15:0] format_version;
      logic [31:0] max_instructions;
      logic [31:0] max_operand_len;
      logic [31:0] max_image_len;
   } cfg_type;

   typedef struct packed {
      logic       fire;
      logic [7:0] data_byte;
      logic       last_byte;
   } step_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] instr_count;
   } verdict_type;

   typedef struct packed {
      logic [1:0] cont;
      logic       pend;
   } utf8_type;

   function automatic utf8_type utf8_feed(utf8_type cur, logic [7:0] c);
      utf8_type r;
      r = cur;
      if (cur.cont != 2'd0) begin
         if ((c & UTF8_CONT_MASK) != UTF8_CONT_CODE) r.pend = 1'b1;
         r.cont = cur.cont - 2'd1;
      end else if (!c[7]) begin
         r = cur;
      end else if ((c & UTF8_LEAD2_MASK) == UTF8_LEAD2_CODE) begin
         r.cont = 2'd1;
         if (c < UTF8_LEAD2_MIN) r.pend = 1'b1;
      end else if ((c & UTF8_LEAD3_MASK) == UTF8_LEAD3_CODE) begin
         r.cont = 2'd2;
      end else if ((c & UTF8_LEAD4_MASK) == UTF8_LEAD4_CODE) begin
         r.cont = 2'd3;
         if (c > UTF8_LEAD4_MAX) r.pend = 1'b1;
      end else begin
         r.pend = 1'b1;
      end
      return r;
   endfunction

   function automatic logic utf8_bad(utf8_type u);
      return u.pend || (u.cont != 2'd0);
   endfunction

endpackage

[rtl/pcv_if.sv]
// Handshake channel interfaces: byte request, verdict response, CSR write.
// Depends on nothing.
interface pcv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pcv_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] instr_count;

   modport source (output valid, output status, output instr_count, input ready);
   modport sink   (input valid, input status, input instr_count, output ready);
endinterface

interface pcv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [31:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

[rtl/pcv_csr_regs.sv]
// Configuration registers of the validator, written through the CSR channel.
// Depends on pcv_pkg and pcv_csr_if.
module pcv_csr_regs
   import pcv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   pcv_csr_if.sink         csr,
   output cfg_type         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.reg_index)
            CSR_MAGIC:       cfg_in.magic_word       = csr.write_data;
            CSR_VERSION:     cfg_in.format_version   = csr.write_data[15:0];
            CSR_MAX_INSTR:   cfg_in.max_instructions = csr.write_data;
            CSR_MAX_OPERAND: cfg_in.max_operand_len  = csr.write_data;
            CSR_MAX_IMAGE:   cfg_in.max_image_len    = csr.write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word       <= RST_MAGIC;
         cfg_ff.format_version   <= RST_VERSION;
         cfg_ff.max_instructions <= RST_MAX_INSTR;
         cfg_ff.max_operand_len  <= RST_MAX_OPERAND;
         cfg_ff.max_image_len    <= RST_MAX_IMAGE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/pcv_parser.sv]
// Container parse state machine: consumes one byte per step, gives the verdict
// on the last byte and restarts. Depends on pcv_pkg.
module pcv_parser
   import pcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  step_type    step,
   output verdict_type verdict
);

   localparam logic [3:0] HDR_MAGIC_END   = 4'd3;
   localparam logic [3:0] HDR_VERSION_END = 4'd5;
   localparam logic [3:0] HDR_FLAGS_END   = 4'd7;
   localparam logic [3:0] HDR_COUNT_END   = 4'd11;
   localparam logic [3:0] LEN_LAST        = 4'd3;

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] hdr_count_ff, hdr_count_in;
   logic [31:0] instr_left_ff, instr_left_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   utf8_type    utf_ff, utf_in;
   status_type  err_ff, err_in;
   logic        stop_ff, stop_in;

   logic [31:0] acc_shift;
   utf8_type    utf_step;
   logic [7:0]  c;

   function automatic status_type keep_first(status_type first, status_type code);
      return (first != ST_OK) ? first : code;
   endfunction

   always_comb begin
      c             = step.data_byte;
      acc_shift     = {acc_ff[23:0], c};
      utf_step      = utf8_feed(utf_ff, c);
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      hdr_count_in  = hdr_count_ff;
      instr_left_in = instr_left_ff;
      bytes_left_in = bytes_left_ff;
      utf_in        = utf_ff;
      err_in        = err_ff;
      stop_in       = stop_ff;

      if (step.fire) begin
         unique case (phase_ff)
            PH_HEADER: begin
               acc_in = acc_shift;
               idx_in = idx_ff + 4'd1;
               if (idx_ff == HDR_MAGIC_END && acc_shift != cfg.magic_word)
                  err_in = keep_first(err_ff, ST_MAGIC);
               if (idx_ff == HDR_VERSION_END && acc_shift[15:0] != cfg.format_version)
                  err_in = keep_first(err_ff, ST_VERSION);
               if (idx_ff == HDR_FLAGS_END && acc_shift[15:0] != 16'd0)
                  err_in = keep_first(err_ff, ST_FLAGS);
               if (idx_ff == HDR_COUNT_END) begin
                  hdr_count_in = acc_shift;
                  idx_in       = 4'd0;
                  if (acc_shift == 32'd0 || acc_shift > cfg.max_instructions)
                     err_in = keep_first(err_ff, ST_COUNT);
                  if (err_in != ST_OK) begin
                     phase_in = PH_DRAIN;
                  end else begin
                     instr_left_in = acc_shift;
                     phase_in      = PH_OPCODE;
                  end
               end
            end
            PH_OPCODE: begin
               if (c < OPCODE_MIN || c > OPCODE_STOP) begin
                  err_in   = keep_first(err_ff, ST_OPCODE);
                  phase_in = PH_DRAIN;
               end else begin
                  stop_in  = stop_ff | (c == OPCODE_STOP);
                  phase_in = PH_TAG;
               end
            end
            PH_TAG: begin
               if (c == TAG_NONE) begin
                  instr_left_in = instr_left_ff - 32'd1;
                  phase_in      = (instr_left_ff == 32'd1) ? PH_IMGLEN : PH_OPCODE;
               end else if (c == TAG_OPERAND) begin
                  idx_in   = 4'd0;
                  phase_in = PH_OPLEN;
               end else begin
                  err_in   = keep_first(err_ff, ST_TAG);
                  phase_in = PH_DRAIN;
               end
            end
            PH_OPLEN, PH_IMGLEN: begin
               acc_in = acc_shift;
               if (idx_ff != LEN_LAST) begin
                  idx_in = idx_ff + 4'd1;
               end else begin
                  idx_in        = 4'd0;
                  bytes_left_in = acc_shift;
                  utf_in        = '0;
                  if (phase_ff == PH_OPLEN) begin
                     if (acc_shift > cfg.max_operand_len) begin
                        err_in   = keep_first(err_ff, ST_TRUNC);
                        phase_in = PH_DRAIN;
                     end else if (acc_shift == 32'd0) begin
                        instr_left_in = instr_left_ff - 32'd1;
                        phase_in = (instr_left_ff == 32'd1) ? PH_IMGLEN : PH_OPCODE;
                     end else begin
                        phase_in = PH_OPDATA;
                     end
                  end else begin
                     if (acc_shift > cfg.max_image_len) begin
                        err_in   = keep_first(err_ff, ST_TRUNC);
                        phase_in = PH_DRAIN;
                     end else if (acc_shift == 32'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_IMGDATA;
                     end
                  end
               end
            end
            PH_OPDATA: begin
               utf_in        = utf_step;
               bytes_left_in = bytes_left_ff - 32'd1;
               if (bytes_left_ff == 32'd1) begin
                  if (utf8_bad(utf_step)) begin
                     err_in   = keep_first(err_ff, ST_OPUTF8);
                     phase_in = PH_DRAIN;
                  end else begin
                     instr_left_in = instr_left_ff - 32'd1;
                     phase_in = (instr_left_ff == 32'd1) ? PH_IMGLEN : PH_OPCODE;
                  end
               end
            end
            PH_IMGDATA: begin
               utf_in        = utf_step;
               bytes_left_in = bytes_left_ff - 32'd1;
               if (bytes_left_ff == 32'd1) phase_in = PH_DONE;
            end
            PH_DONE: begin
               err_in   = keep_first(err_ff, ST_TRAILING);
               phase_in = PH_DRAIN;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      verdict.instr_count = hdr_count_in;
      if (phase_in == PH_HEADER)      verdict.status = ST_TRUNC;
      else if (err_in != ST_OK)       verdict.status = err_in;
      else if (phase_in != PH_DONE)   verdict.status = ST_TRUNC;
      else if (utf8_bad(utf_in))      verdict.status = ST_IMGUTF8;
      else if (!stop_in)              verdict.status = ST_NOSTOP;
      else                            verdict.status = ST_OK;

      if (step.fire && step.last_byte) begin
         phase_in      = PH_HEADER;
         idx_in        = 4'd0;
         acc_in        = 32'd0;
         hdr_count_in  = 32'd0;
         instr_left_in = 32'd0;
         bytes_left_in = 32'd0;
         utf_in        = '0;
         err_in        = ST_OK;
         stop_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         idx_ff        <= 4'd0;
         acc_ff        <= 32'd0;
         hdr_count_ff  <= 32'd0;
         instr_left_ff <= 32'd0;
         bytes_left_ff <= 32'd0;
         utf_ff        <= '0;
         err_ff        <= ST_OK;
         stop_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         acc_ff        <= acc_in;
         hdr_count_ff  <= hdr_count_in;
         instr_left_ff <= instr_left_in;
         bytes_left_ff <= bytes_left_in;
         utf_ff        <= utf_in;
         err_ff        <= err_in;
         stop_ff       <= stop_in;
      end
   end

endmodule

[rtl/program_container_validator.sv]
// Program container validator top level: input register, parser, result register.
// A last byte passes the input register; its verdict goes to the result register.
// Throughput is one byte per cycle; the input register waits only while it holds
// a last byte and the result register holds a verdict that rsp is not taking.
// Reset (synchronous, active high) returns the parser to the header phase and the
// CSRs to their defaults; there is no clearing pass.
module program_container_validator
   import pcv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pcv_req_if.sink    req_ch,
   pcv_rsp_if.source  rsp_ch,
   pcv_csr_if.sink    csr_ch
);

   cfg_type     cfg;
   step_type    step;
   verdict_type verdict;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   verdict_type out_ff;
   logic        proc_fire;
   logic        req_fire;

   pcv_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   pcv_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (step),
      .verdict (verdict)
   );

   assign proc_fire    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || proc_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign step.fire      = proc_fire;
   assign step.data_byte = in_byte_ff;
   assign step.last_byte = in_last_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)       in_valid_in = 1'b1;
      else if (proc_fire) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (proc_fire && in_last_ff) out_valid_in = 1'b1;
      else if (rsp_ch.ready)       out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
      if (proc_fire && in_last_ff) out_ff <= verdict;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.instr_count = out_ff.instr_count;

endmodule

[rtl/pcv_checker.sv]
// Port-level checks on the verdict channel, bound to the top level.
// Depends on pcv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcv_checker
   import pcv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic [31:0] rsp_instr_count
);

   `ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid, "verdict dropped while stalled")
   `ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_instr_count), "verdict changed while stalled")
   `ASSERT_IMPLIES(a_status_range, rsp_valid, rsp_status <= ST_NOSTOP, "status code out of range")
   `ASSERT_IMPLIES(a_count_after_header, rsp_valid && (rsp_status == ST_OK || rsp_status >= ST_OPCODE), rsp_instr_count != 32'd0, "zero count past a good header")

endmodule

bind program_container_validator pcv_checker u_pcv_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_instr_count (rsp_ch.instr_count)
);

[tb/program_container_validator_tb.sv]
// Testbench for program_container_validator: random and directed byte streams of program
// containers, checked against an in-bench parser model held in a small scoreboard class.
// Depends on pcv_pkg (rtl/pcv_pkg.sv) and the channel interfaces in rtl/pcv_if.sv.
import pcv_pkg::*;

class container_checker;
   cfg_type     cfg;
   phase_type   phase;
   logic [3:0]  field_idx;
   logic [31:0] field_acc;
   logic [31:0] hdr_count;
   logic [31:0] instr_left;
   logic [31:0] bytes_left;
   logic [1:0]  cont_left;
   logic        utf8_err;
   logic        stop_seen;
   status_type  first_err;
   verdict_type expected_q[$];
   int unsigned errors;
   int unsigned verdict_count;
   int unsigned parsed_bytes;

   function new();
      cfg.magic_word       = RST_MAGIC;
      cfg.format_version   = RST_VERSION;
      cfg.max_instructions = RST_MAX_INSTR;
      cfg.max_operand_len  = RST_MAX_OPERAND;
      cfg.max_image_len    = RST_MAX_IMAGE;
      errors        = 0;
      verdict_count = 0;
      parsed_bytes  = 0;
      restart();
   endfunction

   function void restart();
      phase      = PH_HEADER;
      field_idx  = '0;
      field_acc  = '0;
      hdr_count  = '0;
      instr_left = '0;
      bytes_left = '0;
      cont_left  = '0;
      utf8_err   = 1'b0;
      first_err  = ST_OK;
      stop_seen  = 1'b0;
   endfunction

   function void write_reg(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_MAGIC:       cfg.magic_word       = data;
         CSR_VERSION:     cfg.format_version   = data[15:0];
         CSR_MAX_INSTR:   cfg.max_instructions = data;
         CSR_MAX_OPERAND: cfg.max_operand_len  = data;
         CSR_MAX_IMAGE:   cfg.max_image_len    = data;
         default: ;
      endcase
   endfunction

   function void flag_error(status_type code);
      if (first_err == ST_OK) first_err = code;
      phase = PH_DRAIN;
   endfunction

   function void feed_utf8(logic [7:0] c);
      if (cont_left != 2'd0) begin
         if ((c & UTF8_CONT_MASK) != UTF8_CONT_CODE) utf8_err = 1'b1;
         cont_left--;
      end else if (c[7]) begin
         if ((c & UTF8_LEAD2_MASK) == UTF8_LEAD2_CODE) begin
            cont_left = 2'd1;
            if (c < UTF8_LEAD2_MIN) utf8_err = 1'b1;
         end else if ((c & UTF8_LEAD3_MASK) == UTF8_LEAD3_CODE) begin
            cont_left = 2'd2;
         end else if ((c & UTF8_LEAD4_MASK) == UTF8_LEAD4_CODE) begin
            cont_left = 2'd3;
            if (c > UTF8_LEAD4_MAX) utf8_err = 1'b1;
         end else begin
            utf8_err = 1'b1;
         end
      end
   endfunction

   function logic utf8_broken();
      return utf8_err || (cont_left != 2'd0);
   endfunction

   function void next_instr();
      instr_left--;
      field_idx = '0;
      field_acc = '0;
      phase = (instr_left == 0) ? PH_IMGLEN : PH_OPCODE;
   endfunction

   function void parse_byte(logic [7:0] c);
      case (phase)
         PH_HEADER: begin
            field_acc = {field_acc[23:0], c};
            if (field_idx == 4'd3 && field_acc != cfg.magic_word && first_err == ST_OK)
               first_err = ST_MAGIC;
            if (field_idx == 4'd5 && field_acc[15:0] != cfg.format_version &&
                first_err == ST_OK)
               first_err = ST_VERSION;
            if (field_idx == 4'd7 && field_acc[15:0] != 16'd0 && first_err == ST_OK)
               first_err = ST_FLAGS;
            if (field_idx == 4'd11) begin
               hdr_count = field_acc;
               if ((hdr_count == 0 || hdr_count > cfg.max_instructions) && first_err == ST_OK)
                  first_err = ST_COUNT;
               field_idx = '0;
               field_acc = '0;
               if (first_err != ST_OK) begin
                  phase = PH_DRAIN;
               end else begin
                  instr_left = hdr_count;
                  phase = PH_OPCODE;
               end
            end else begin
               field_idx++;
            end
         end
         PH_OPCODE: begin
            if (c < OPCODE_MIN || c > OPCODE_STOP) begin
               flag_error(ST_OPCODE);
            end else begin
               if (c == OPCODE_STOP) stop_seen = 1'b1;
               phase = PH_TAG;
            end
         end
         PH_TAG: begin
            if (c == TAG_NONE) begin
               next_instr();
            end else if (c == TAG_OPERAND) begin
               field_idx = '0;
               field_acc = '0;
               phase = PH_OPLEN;
            end else begin
               flag_error(ST_TAG);
            end
         end
         PH_OPLEN, PH_IMGLEN: begin
            field_acc = {field_acc[23:0], c};
            if (field_idx < 4'd3) begin
               field_idx++;
            end else begin
               field_idx = '0;
               bytes_left = field_acc;
               field_acc = '0;
               cont_left = '0;
               utf8_err = 1'b0;
               if (phase == PH_OPLEN) begin
                  if (bytes_left > cfg.max_operand_len) flag_error(ST_TRUNC);
                  else if (bytes_left == 0) next_instr();
                  else phase = PH_OPDATA;
               end else begin
                  if (bytes_left > cfg.max_image_len) flag_error(ST_TRUNC);
                  else if (bytes_left == 0) phase = PH_DONE;
                  else phase = PH_IMGDATA;
               end
            end
         end
         PH_OPDATA: begin
            feed_utf8(c);
            bytes_left--;
            if (bytes_left == 0) begin
               if (utf8_broken()) flag_error(ST_OPUTF8);
               else next_instr();
            end
         end
         PH_IMGDATA: begin
            feed_utf8(c);
            bytes_left--;
            if (bytes_left == 0) phase = PH_DONE;
         end
         PH_DONE: flag_error(ST_TRAILING);
         default: ;
      endcase
   endfunction

   function void note_request(logic [7:0] c, logic last);
      verdict_type v;
      if (phase != PH_DRAIN) parsed_bytes++;
      parse_byte(c);
      if (last) begin
         if (phase == PH_HEADER) v.status = ST_TRUNC;
         else if (first_err != ST_OK) v.status = first_err;
         else if (phase != PH_DONE) v.status = ST_TRUNC;
         else if (utf8_broken()) v.status = ST_IMGUTF8;
         else if (!stop_seen) v.status = ST_NOSTOP;
         else v.status = ST_OK;
         v.instr_count = hdr_count;
         expected_q.push_back(v);
         restart();
      end
   endfunction

   function void check_verdict(status_type st, logic [31:0] count);
      verdict_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: verdict with none pending: status %0d, instr_count %0d",
                  $time, st, count);
         return;
      end
      want = expected_q.pop_front();
      verdict_count++;
      if (st !== want.status) begin
         errors++;
         $display("%0t: status expected %0d, got %0d", $time, want.status, st);
      end
      if (count !== want.instr_count) begin
         errors++;
         $display("%0t: instr_count expected %0d, got %0d", $time, want.instr_count, count);
      end
   endfunction
endclass

module program_container_validator_tb;
   localparam int unsigned CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcv_req_if req();
   pcv_rsp_if rsp();
   pcv_csr_if csr();

   program_container_validator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   container_checker verdicts = new();

   logic [7:0]  container_bytes[$];
   int unsigned burst_left = 0;
   int unsigned containers_sent = 0;
   int unsigned cycles = 0;
   logic [7:0]  rsp_tick = '0;
   logic [1:0]  rsp_mode = '0;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) verdicts.note_request(req.data_byte, req.last_byte);
      if (!reset && rsp.valid && rsp.ready) verdicts.check_verdict(rsp.status, rsp.instr_count);
   end

   // response back-pressure: the pattern is picked anew at random each time the low six bits of rsp_tick are zero
   always @(posedge clock) begin
      rsp_tick <= rsp_tick + 8'd1;
      if (rsp_tick[5:0] == 6'd0) rsp_mode <= 2'($urandom_range(0, 3));
      case (rsp_mode)
         2'd0: rsp.ready <= 1'b1;
         2'd1: rsp.ready <= (rsp_tick % 3 == 0);
         2'd2: rsp.ready <= 1'($urandom_range(0, 1));
         default: rsp.ready <= (rsp_tick[3:0] > 4'd9);
      endcase
   end

   function automatic int unsigned capped(logic [31:0] limit, int unsigned most);
      return (limit < most) ? int'(limit) : most;
   endfunction

   function automatic void push8(int unsigned v);
      logic [7:0] b;
      b = v[7:0];
      container_bytes.push_back(b);
   endfunction

   function automatic void push32(logic [31:0] v);
      push8(v[31:24]);
      push8(v[23:16]);
      push8(v[15:8]);
      push8(v[7:0]);
   endfunction

   // UTF-8 text, mostly well formed, with occasional bad leads, stray continuations
   // and sequences cut off by the end of the field
   function automatic void append_text(int unsigned len);
      int unsigned left, kind, n, k;
      left = len;
      while (left > 0) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            case ($urandom_range(0, 2))
               0: push8($urandom_range(8'hc0, 8'hc1));
               1: push8($urandom_range(8'hf5, 8'hff));
               default: push8($urandom_range(8'h80, 8'hbf));
            endcase
            left--;
         end else begin
            n = (kind < 10) ? 1 : (kind < 14) ? 2 : (kind < 17) ? 3 : 4;
            if (n > left && $urandom_range(0, 3) != 0) n = 1;
            case (n)
               1: push8($urandom_range(8'h00, 8'h7f));
               2: push8($urandom_range(8'hc2, 8'hdf));
               3: push8($urandom_range(8'he0, 8'hef));
               default: push8($urandom_range(8'hf0, 8'hf4));
            endcase
            left--;
            for (k = 1; k < n && left > 0; k++) begin
               push8($urandom_range(8'h80, 8'hbf));
               left--;
            end
         end
      end
   endfunction

   function automatic void build_container();
      int unsigned mode, n_instr, i, len, keep;
      int          stop_at;
      logic [31:0] count;
      cfg_type     c;
      c = verdicts.cfg;
      container_bytes.delete();
      mode = $urandom_range(0, 99);
      n_instr = $urandom_range(1, capped(c.max_instructions, 4));
      count = n_instr;
      if (mode == 3) count = '0;
      if (mode == 4) count = c.max_instructions + 1;
      push32((mode == 0) ? 32'($urandom) : c.magic_word);
      push8((mode == 1) ? $urandom : c.format_version[15:8]);
      push8((mode == 1) ? $urandom : c.format_version[7:0]);
      push32((mode == 2) ? {16'd0, 16'($urandom_range(1, 65535))} : 32'd0);
      push32(count);
      stop_at = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, n_instr - 1);
      for (i = 0; i < n_instr; i++) begin
         push8((i == stop_at) ? OPCODE_STOP : $urandom_range(OPCODE_MIN, OPCODE_STOP));
         if (mode >= 33 && mode <= 35 && i == 0 && c.max_operand_len != '1) begin
            push8(TAG_OPERAND);
            push32(c.max_operand_len + 1);
         end else if ($urandom_range(0, 1) == 0) begin
            push8(TAG_NONE);
         end else begin
            push8(TAG_OPERAND);
            len = $urandom_range(0, capped(c.max_operand_len, 4));
            push32(len);
            append_text(len);
         end
      end
      if (mode >= 29 && mode <= 32 && c.max_image_len != '1) begin
         push32(c.max_image_len + 1);
      end else begin
         len = $urandom_range(0, capped(c.max_image_len, 6));
         push32(len);
         append_text(len);
      end
      if (mode >= 5 && mode <= 14) begin
         i = $urandom_range(0, container_bytes.size() - 1);
         container_bytes[i] = 8'($urandom);
      end else if (mode >= 15 && mode <= 22) begin
         keep = $urandom_range(1, container_bytes.size() - 1);
         while (container_bytes.size() > keep) void'(container_bytes.pop_back());
      end else if (mode >= 23 && mode <= 28) begin
         repeat ($urandom_range(1, 3)) push8($urandom);
      end
   endfunction

   // the sender runs in bursts with random gaps between them
   task automatic send_stream();
      int unsigned k, gap;
      for (k = 0; k < container_bytes.size(); k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0) begin
               req.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         req.valid     <= 1'b1;
         req.data_byte <= container_bytes[k];
         req.last_byte <= (k == container_bytes.size() - 1);
         @(posedge clock);
         while (!req.ready) @(posedge clock);
      end
      containers_sent++;
   endtask

   task automatic run_random(int unsigned byte_goal);
      while (verdicts.parsed_bytes < byte_goal) begin
         build_container();
         send_stream();
      end
   endtask

   task automatic drain_verdicts();
      req.valid <= 1'b0;
      do @(posedge clock); while (verdicts.expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, logic [31:0] data);
      csr.valid      <= 1'b1;
      csr.reg_index  <= idx;
      csr.write_data <= data;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      verdicts.write_reg(idx, data);
   endtask

   task automatic load_config(cfg_type c);
      put_reg(CSR_MAGIC, c.magic_word);
      put_reg(CSR_VERSION, {16'($urandom), c.format_version});
      put_reg(CSR_MAX_INSTR, c.max_instructions);
      put_reg(CSR_MAX_OPERAND, c.max_operand_len);
      put_reg(CSR_MAX_IMAGE, c.max_image_len);
      csr.valid <= 1'b0;
   endtask

   initial begin
      cfg_type c;
      req.valid      = 1'b0;
      req.data_byte  = '0;
      req.last_byte  = 1'b0;
      rsp.ready      = 1'b0;
      csr.valid      = 1'b0;
      csr.reg_index  = CSR_MAGIC;
      csr.write_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // defaults: one-byte stream, smallest good container, zero count
      container_bytes = '{8'hff};
      send_stream();
      container_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                          8'h00, 8'h00, 8'h00, 8'h01, OPCODE_STOP, TAG_NONE,
                          8'h00, 8'h00, 8'h00, 8'h00};
      send_stream();
      container_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                          8'h00, 8'h00, 8'h00, 8'h00};
      send_stream();
      run_random(190);
      drain_verdicts();

      c.magic_word       = $urandom;
      c.format_version   = 16'($urandom);
      c.max_instructions = 32'd3;
      c.max_operand_len  = 32'd2;
      c.max_image_len    = 32'd4;
      load_config(c);
      run_random(380);
      drain_verdicts();

      c.magic_word       = '1;
      c.format_version   = '1;
      c.max_instructions = 32'd1;
      c.max_operand_len  = '0;
      c.max_image_len    = '0;
      load_config(c);
      run_random(570);
      drain_verdicts();

      c.magic_word       = '0;
      c.format_version   = '0;
      c.max_instructions = '1;
      c.max_operand_len  = '1;
      c.max_image_len    = '1;
      load_config(c);
      run_random(760);
      drain_verdicts();

      c.magic_word       = $urandom;
      c.format_version   = 16'($urandom);
      c.max_instructions = $urandom_range(1, 5);
      c.max_operand_len  = $urandom_range(0, 5);
      c.max_image_len    = $urandom_range(0, 7);
      load_config(c);
      run_random(950);
      while (containers_sent < 40) begin
         build_container();
         send_stream();
      end
      drain_verdicts();

      $display("Sent %0d containers, %0d bytes parsed, %0d verdicts checked",
               containers_sent, verdicts.parsed_bytes, verdicts.verdict_count);
      $display("Register settings: reset, small limits, both extremes, random");
      if (verdicts.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
